@@ sv/assert_macros.svh @@
// Assertion macros shared by the array core modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/iiea_pkg.sv @@
// Constants, codes and control types of the indexed insert/erase array
package iiea_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int OP_W     = 2;
    localparam int POS_W    = 5;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 5;
    localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_ERASE  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic load_req;
        logic execute;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_dp_stat;

endpackage

@@ sv/iiea_if.sv @@
// Request and response channel interfaces of the array core
interface iiea_req_if import iiea_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] item_value;

    modport source (output valid, output op, output position, output item_value,
                    input ready);
    modport sink   (input valid, input op, input position, input item_value,
                    output ready);
endinterface

interface iiea_rsp_if import iiea_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic [LEN_W-1:0]         new_length;
    logic signed [DATA_W-1:0] read_value;

    modport source (output valid, output status, output new_length, output read_value,
                    input ready);
    modport sink   (input valid, input status, input new_length, input read_value,
                    output ready);
endinterface

@@ sv/indexed_insert_erase_array_core.sv @@
// A request word accepted in the idle state is captured into the request registers and
// executes once the response register is free; its response word is then registered.
// No new request is taken until the current one has executed (the capture and
// execute steps of the controller); all entries shift in parallel in the execute cycle.
// A new request is taken while the previous response word still waits.
// Reset (synchronous, active low) clears the length and handshake state, not the entries.
module indexed_insert_erase_array_core import iiea_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    iiea_req_if.sink   i_req,
    iiea_rsp_if.source o_rsp
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    iiea_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    iiea_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_op         (i_req.op),
        .i_position   (i_req.position),
        .i_item_value (i_req.item_value),
        .o_status     (o_rsp.status),
        .o_new_length (o_rsp.new_length),
        .o_read_value (o_rsp.read_value)
    );

endmodule

@@ sv/iiea_ctrl.sv @@
// Controller: request capture, execute step and response valid tracking
`include "assert_macros.svh"

module iiea_ctrl import iiea_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign o_in_ready    = (r_state == S_IDLE);
    assign out_free      = !r_out_valid || i_out_ready;
    assign o_cmd.load_req = o_in_ready && i_in_valid;
    // execute only when the response register can take the new word
    assign o_cmd.execute  = (r_state == S_EXEC) && out_free;
    assign o_out_valid    = r_out_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.load_req) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (o_cmd.execute) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.execute) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `ASSERT_NEXT(a_exec_gives_word, o_cmd.execute, r_out_valid, "execute left no response word")
    `ASSERT_NEXT(a_accept_to_exec, o_cmd.load_req, (r_state == S_EXEC), "accepted word idle")
    `ASSERT_ALWAYS(a_flags_exclusive, !(i_stat.full && i_stat.empty), "array both full and empty")

endmodule

@@ sv/iiea_dp.sv @@
// Datapath: entry register chain, length counter, request and response registers
`include "assert_macros.svh"

module iiea_dp import iiea_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    output t_dp_stat                 o_stat,
    input  logic [OP_W-1:0]          i_op,
    input  logic [POS_W-1:0]         i_position,
    input  logic signed [DATA_W-1:0] i_item_value,
    output logic [STATUS_W-1:0]      o_status,
    output logic [LEN_W-1:0]         o_new_length,
    output logic signed [DATA_W-1:0] o_read_value
);

    logic [DATA_W-1:0]   r_entry [CAPACITY];
    logic [DATA_W-1:0]   n_entry [CAPACITY];
    logic [CNT_W-1:0]    r_count, n_count;

    logic [OP_W-1:0]     r_op;
    logic [POS_W-1:0]    r_pos;
    logic [DATA_W-1:0]   r_val;

    logic [STATUS_W-1:0] r_status;
    logic [LEN_W-1:0]    r_len;
    logic [DATA_W-1:0]   r_rd;

    logic [CMP_W-1:0]    pos_ext, cnt_ext;
    logic [IDX_W-1:0]    rd_idx;
    logic [STATUS_W-1:0] status;
    logic                do_insert, do_erase;
    logic [DATA_W-1:0]   rd_value;

    assign pos_ext = CMP_W'(r_pos);
    assign cnt_ext = CMP_W'(r_count);
    assign rd_idx  = pos_ext[IDX_W-1:0];

    assign o_stat.full  = (r_count == CNT_W'(CAPACITY));
    assign o_stat.empty = (r_count == '0);

    always_comb begin
        status = ST_BAD_INDEX;
        case (r_op)
            OP_INSERT: begin
                if (o_stat.full) begin
                    status = ST_FULL;
                end else if (pos_ext > cnt_ext) begin
                    status = ST_BAD_INDEX;
                end else begin
                    status = ST_OK;
                end
            end
            OP_ERASE, OP_READ: begin
                if (o_stat.empty) begin
                    status = ST_EMPTY;
                end else if (pos_ext >= cnt_ext) begin
                    status = ST_BAD_INDEX;
                end else begin
                    status = ST_OK;
                end
            end
            default: begin
                status = ST_BAD_INDEX;
            end
        endcase
    end

    assign do_insert = i_cmd.execute && (r_op == OP_INSERT) && (status == ST_OK);
    assign do_erase  = i_cmd.execute && (r_op == OP_ERASE) && (status == ST_OK);
    assign rd_value  = ((r_op == OP_READ) && (status == ST_OK)) ? r_entry[rd_idx] : '0;

    // each entry keeps its value or picks its lower neighbor, the new word, or its upper neighbor
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_entry[i] = r_entry[i];
            if (do_insert) begin
                if (CMP_W'(i) == pos_ext) begin
                    n_entry[i] = r_val;
                end else if ((CMP_W'(i) > pos_ext) && (i > 0)) begin
                    n_entry[i] = r_entry[(i > 0) ? i - 1 : 0];
                end
            end else if (do_erase) begin
                if ((CMP_W'(i) >= pos_ext) && (i < CAPACITY - 1)) begin
                    n_entry[i] = r_entry[(i < CAPACITY - 1) ? i + 1 : i];
                end
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (do_insert) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_erase) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < CAPACITY; i++) begin
            r_entry[i] <= n_entry[i];
        end
        if (i_cmd.load_req) begin
            r_op  <= i_op;
            r_pos <= i_position;
            r_val <= i_item_value;
        end
        if (i_cmd.execute) begin
            r_status <= status;
            r_len    <= LEN_W'(n_count);
            r_rd     <= rd_value;
        end
    end

    assign o_status     = r_status;
    assign o_new_length = r_len;
    assign o_read_value = r_rd;

    `ASSERT_ALWAYS(a_count_max, (r_count <= CNT_W'(CAPACITY)), "length above capacity")
    `ASSERT_NEXT(a_insert_grows, do_insert, (r_count == $past(r_count) + CNT_W'(1)), "insert did not grow")

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the indexed insert/erase array core
module testbench;
    import iiea_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [LEN_W-1:0]         new_length;
        logic signed [DATA_W-1:0] read_value;
    } t_array_resp;

    logic i_clk = 1'b0;
    logic i_rst_n;

    iiea_req_if req_if ();
    iiea_rsp_if rsp_if ();

    indexed_insert_erase_array_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Shadow copy of the array contents
    logic signed [DATA_W-1:0] shadow_entries [CAPACITY];
    int                       shadow_count;

    t_array_resp pending_resp_q [$];

    int send_idle_pct;
    int recv_idle_pct;
    int recv_hold_cycles;
    int error_count;
    int requests_sent;
    int responses_checked;
    int deepest_length;
    int status_hits [4];

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #(5_000_000);
        $display("Regression FAIL");
        $finish;
    end

    // Apply one request to the shadow array and return the response it should give
    function automatic t_array_resp apply_array_request(input logic [OP_W-1:0] op,
                                                        input logic [POS_W-1:0] pos,
                                                        input logic signed [DATA_W-1:0] val);
        t_array_resp rsp;
        int          i;
        rsp.status     = ST_BAD_INDEX;
        rsp.read_value = '0;
        case (op)
            OP_INSERT: begin
                if (shadow_count >= CAPACITY) begin
                    rsp.status = ST_FULL;
                end else if (int'(pos) > shadow_count) begin
                    rsp.status = ST_BAD_INDEX;
                end else begin
                    for (i = shadow_count; i > int'(pos); i--)
                        shadow_entries[i] = shadow_entries[i-1];
                    shadow_entries[pos] = val;
                    shadow_count++;
                    rsp.status = ST_OK;
                end
            end
            OP_ERASE, OP_READ: begin
                if (shadow_count == 0) begin
                    rsp.status = ST_EMPTY;
                end else if (int'(pos) >= shadow_count) begin
                    rsp.status = ST_BAD_INDEX;
                end else if (op == OP_READ) begin
                    rsp.read_value = shadow_entries[pos];
                    rsp.status     = ST_OK;
                end else begin
                    for (i = int'(pos) + 1; i < shadow_count; i++)
                        shadow_entries[i-1] = shadow_entries[i];
                    shadow_count--;
                    rsp.status = ST_OK;
                end
            end
            default: ;
        endcase
        rsp.new_length = shadow_count[LEN_W-1:0];
        return rsp;
    endfunction

    // Receiver: random ready, or a forced hold-off while recv_hold_cycles runs down
    always @(negedge i_clk) begin
        if (recv_hold_cycles > 0) begin
            rsp_if.ready <= 1'b0;
            recv_hold_cycles = recv_hold_cycles - 1;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: check response words first, then predict from accepted request words
    always @(posedge i_clk) begin
        t_array_resp want;
        if (i_rst_n) begin
            if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
                if (pending_resp_q.size() == 0) begin
                    $display("%0t: response word with nothing expected: status %0d length %0d value %0d",
                             $time, rsp_if.status, rsp_if.new_length, rsp_if.read_value);
                    error_count++;
                end else begin
                    want = pending_resp_q.pop_front();
                    responses_checked++;
                    status_hits[want.status]++;
                    if (rsp_if.status !== want.status) begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, rsp_if.status);
                        error_count++;
                    end
                    if (rsp_if.new_length !== want.new_length) begin
                        $display("%0t: new_length mismatch: expected %0d, actual %0d",
                                 $time, want.new_length, rsp_if.new_length);
                        error_count++;
                    end
                    if (rsp_if.read_value !== want.read_value) begin
                        $display("%0t: read_value mismatch: expected %0d, actual %0d",
                                 $time, want.read_value, rsp_if.read_value);
                        error_count++;
                    end
                end
            end
            if (req_if.valid === 1'b1 && req_if.ready === 1'b1) begin
                pending_resp_q.push_back(apply_array_request(req_if.op, req_if.position,
                                                             req_if.item_value));
                requests_sent++;
                if (shadow_count > deepest_length)
                    deepest_length = shadow_count;
            end
        end
    end

    // Offer one request word; called and returns just after a falling edge
    task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                input logic signed [DATA_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.op         <= op;
        req_if.position   <= pos;
        req_if.item_value <= val;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        @(negedge i_clk);
    endtask

    task automatic wait_for_responses();
        req_if.valid <= 1'b0;
        while (pending_resp_q.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Mostly in-range requests against the current length, with some noise
    task automatic send_random_request(input int insert_pct);
        int                roll;
        int                rest;
        logic [OP_W-1:0]   op;
        logic [POS_W-1:0]  pos;
        roll = $urandom_range(99);
        rest = 96 - insert_pct;
        if (roll < 4)
            op = OP_UNUSED;
        else if (roll < 4 + insert_pct)
            op = OP_INSERT;
        else if (roll < 4 + insert_pct + rest * 6 / 10)
            op = OP_ERASE;
        else
            op = OP_READ;
        if ($urandom_range(99) < 85) begin
            if (op == OP_INSERT)
                pos = POS_W'($urandom_range(shadow_count, 0));
            else if (shadow_count > 0)
                pos = POS_W'($urandom_range(shadow_count - 1, 0));
            else
                pos = POS_W'($urandom_range(31, 0));
        end else begin
            pos = POS_W'($urandom_range(31, 0));
        end
        send_request(op, pos, $urandom);
    endtask

    task automatic test_empty_and_unused();
        send_request(OP_READ, 5'd0, 32'sd0);
        send_request(OP_ERASE, 5'd31, 32'sd0);
        send_request(OP_UNUSED, 5'd0, 32'sd1);
        send_request(OP_INSERT, 5'd1, 32'sd7);
        wait_for_responses();
    endtask

    task automatic test_insert_positions();
        send_request(OP_INSERT, 5'd0, 32'sh7fffffff);
        send_request(OP_INSERT, 5'd1, 32'sh80000000);
        send_request(OP_INSERT, 5'd0, 32'sd0);
        send_request(OP_READ, 5'd3, 32'sd0);
        send_request(OP_READ, 5'd1, 32'sd0);
        send_request(OP_READ, 5'd2, 32'sd0);
        send_request(OP_INSERT, 5'd31, 32'shffffffff);
        wait_for_responses();
    endtask

    task automatic test_fill_and_full();
        while (shadow_count < CAPACITY)
            send_request(OP_INSERT, POS_W'($urandom_range(shadow_count, 0)), $urandom);
        // Full takes priority over a bad index
        send_request(OP_INSERT, 5'd0, 32'sd5);
        send_request(OP_INSERT, 5'd31, 32'sd5);
        send_request(OP_ERASE, POS_W'(CAPACITY), 32'sd0);
        send_request(OP_READ, POS_W'(CAPACITY - 1), 32'sd0);
        send_request(OP_ERASE, POS_W'(CAPACITY - 1), 32'sd0);
        send_request(OP_ERASE, 5'd0, 32'sd0);
        wait_for_responses();
    endtask

    task automatic test_backpressure();
        int n;
        send_idle_pct    = 0;
        recv_hold_cycles = 300;
        for (n = 0; n < 40; n++)
            send_random_request(50);
        wait_for_responses();
        for (n = 0; n < 20; n++)
            send_random_request(50);
        wait_for_responses();
    endtask

    task automatic test_random_traffic(input int num_items, input int send_pct,
                                       input int recv_pct);
        int n;
        int insert_pct;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        insert_pct    = 50;
        for (n = 0; n < num_items; n++) begin
            // Swing between filling and draining so both ends get hit
            if (n % 64 == 0) begin
                case ($urandom_range(2))
                    0: insert_pct = 75;
                    1: insert_pct = 50;
                    default: insert_pct = 25;
                endcase
            end
            send_random_request(insert_pct);
        end
        wait_for_responses();
    endtask

    initial begin
        req_if.valid      = 1'b0;
        req_if.op         = OP_INSERT;
        req_if.position   = '0;
        req_if.item_value = '0;
        rsp_if.ready      = 1'b0;
        i_rst_n           = 1'b0;
        shadow_count      = 0;
        recv_hold_cycles  = 0;
        error_count       = 0;
        requests_sent     = 0;
        responses_checked = 0;
        deepest_length    = 0;
        status_hits       = '{default: 0};
        send_idle_pct     = 11;
        recv_idle_pct     = 56;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_and_unused();
        test_insert_positions();
        test_fill_and_full();
        test_random_traffic(700, 11, 56);
        test_backpressure();
        test_random_traffic(700, 56, 11);
        test_random_traffic(700, 0, 0);

        wait_for_responses();
        repeat (10) @(posedge i_clk);
        $display("Covered %0d requests, %0d responses checked, deepest length %0d",
                 requests_sent, responses_checked, deepest_length);
        $display("Status counts: ok %0d, full %0d, bad index %0d, empty %0d",
                 status_hits[ST_OK], status_hits[ST_FULL], status_hits[ST_BAD_INDEX],
                 status_hits[ST_EMPTY]);
        if (error_count == 0 && pending_resp_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
